[design/rgbbb_pkg.sv]
// ----------------------------------------------------------------------------
// rgbbb_pkg: shared types and constants for the RGB box blur
// Field widths, register indexes, reset values, item and state types.
// ----------------------------------------------------------------------------
package rgbbb_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 1024;
    localparam int unsigned DEF_MAX_HEIGHT = 4096;
    localparam int unsigned DEF_MAX_RADIUS = 7;

    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned CFG_WID_W  = 11;
    localparam int unsigned CFG_HGT_W  = 13;
    localparam int unsigned CFG_RAD_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned FQ_DEPTH   = 2;
    localparam int unsigned FQ_CNT_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_INPUT    = 2'd3;

    localparam logic [CFG_WID_W-1:0] RST_IMAGE_WIDTH   = 11'd640;
    localparam logic [CFG_HGT_W-1:0] RST_IMAGE_HEIGHT  = 13'd480;
    localparam logic [CFG_RAD_W-1:0] RST_WINDOW_RADIUS = 3'd2;

    typedef enum logic {
        K_PIXEL = 1'b0,
        K_DRAIN = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [SAMPLE_W-1:0]  red;
        logic [SAMPLE_W-1:0]  green;
        logic [SAMPLE_W-1:0]  blue;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_CHECK,
        S_READ,
        S_DSET,
        S_DIV,
        S_OUT
    } t_state;

endpackage

[design/rgbbb_front.sv]
// ----------------------------------------------------------------------------
// rgbbb_front: input queue
// Accepts items, tags them as pixel or drain, and holds them for the back end.
// ----------------------------------------------------------------------------
module rgbbb_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic                           i_req_type,
    input  logic [rgbbb_pkg::SAMPLE_W-1:0] i_sample_red,
    input  logic [rgbbb_pkg::SAMPLE_W-1:0] i_sample_green,
    input  logic [rgbbb_pkg::SAMPLE_W-1:0] i_sample_blue,
    output logic                           o_item_valid,
    output rgbbb_pkg::t_item               o_item,
    input  logic                           i_item_pop,
    output logic [rgbbb_pkg::FQ_CNT_W-1:0] o_count
);
    import rgbbb_pkg::*;

    t_item                r_q [FQ_DEPTH];
    logic                 r_wp;
    logic                 r_rp;
    logic [FQ_CNT_W-1:0]  r_cnt;
    logic                 push_ok;
    logic                 pop_ok;
    t_item                in_item;

    assign o_full       = (r_cnt == FQ_CNT_W'(FQ_DEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rp];
    assign o_count      = r_cnt;
    assign push_ok      = i_push && !o_full;
    assign pop_ok       = i_item_pop && o_item_valid;

    always_comb begin
        in_item.kind  = i_req_type ? K_DRAIN : K_PIXEL;
        in_item.red   = i_sample_red;
        in_item.green = i_sample_green;
        in_item.blue  = i_sample_blue;
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[design/rgbbb_back.sv]
// ----------------------------------------------------------------------------
// rgbbb_back: line store, window accumulator and divider
// Writes pixels into the row store, sums each ready clipped window one word
// a cycle, divides by the pixel count and holds the result for the reader.
// ----------------------------------------------------------------------------
module rgbbb_back #(
    parameter int unsigned MAX_WIDTH  = rgbbb_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = rgbbb_pkg::DEF_MAX_HEIGHT,
    parameter int unsigned MAX_RADIUS = rgbbb_pkg::DEF_MAX_RADIUS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [rgbbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rgbbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_item_valid,
    input  rgbbb_pkg::t_item                 i_item,
    output logic                             o_item_pop,
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic [rgbbb_pkg::SAMPLE_W-1:0]   o_blur_red,
    output logic [rgbbb_pkg::SAMPLE_W-1:0]   o_blur_green,
    output logic [rgbbb_pkg::SAMPLE_W-1:0]   o_blur_blue,
    output logic                             o_frame_end
);
    import rgbbb_pkg::*;

    localparam int unsigned STORE_ROWS  = 2 * MAX_RADIUS + 2;
    localparam int unsigned STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
    localparam int unsigned SLOT_W      = $clog2(STORE_ROWS);
    localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
    localparam int unsigned GW_W        = $clog2(MAX_WIDTH + 1);
    localparam int unsigned GH_W        = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned R_W         = $clog2(MAX_RADIUS + 1);
    localparam int unsigned CX_W        = GW_W + 1;
    localparam int unsigned CY_W        = GH_W + 1;
    localparam int unsigned WIN         = 2 * MAX_RADIUS + 1;
    localparam int unsigned CNT_W       = $clog2(WIN * WIN + 1);
    localparam int unsigned SUM_W       = $clog2(255 * WIN * WIN + 1);
    localparam int unsigned IT_W        = $clog2(SUM_W + 1);
    localparam int unsigned WORD_W      = 3 * SAMPLE_W;

    // configuration
    logic [CFG_WID_W-1:0] r_cfg_w;
    logic [CFG_HGT_W-1:0] r_cfg_h;
    logic [CFG_RAD_W-1:0] r_cfg_r;
    logic                 r_cfg_gray;
    logic [GW_W-1:0]      geo_w;
    logic [GH_W-1:0]      geo_h;
    logic [R_W-1:0]       geo_r;

    // stream position
    logic [COL_W-1:0]     r_in_col;
    logic [GH_W-1:0]      r_in_row;
    logic [SLOT_W-1:0]    r_in_slot;
    logic [COL_W-1:0]     r_out_col;
    logic [GH_W-1:0]      r_out_row;
    logic [SLOT_W-1:0]    r_out_slot;

    // window walk
    logic [COL_W-1:0]     r_x0;
    logic [COL_W-1:0]     r_x1;
    logic [GH_W-1:0]      r_y1;
    logic [COL_W-1:0]     r_xx;
    logic [GH_W-1:0]      r_yy;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_issue_done;
    logic                 r_pend;
    logic                 r_last;
    logic [SUM_W-1:0]     r_sum [3];
    logic [CNT_W-1:0]     r_cnt;
    logic [SUM_W-1:0]     r_quo [3];
    logic [CNT_W:0]       r_rem [3];
    logic [IT_W-1:0]      r_iter;

    t_item                r_item;
    t_state               r_state;
    t_state               n_state;

    logic [WORD_W-1:0]    r_mem [STORE_DEPTH];
    logic [WORD_W-1:0]    r_rd_data;

    logic                 r_ovalid;
    logic [SAMPLE_W-1:0]  r_o_red;
    logic [SAMPLE_W-1:0]  r_o_green;
    logic [SAMPLE_W-1:0]  r_o_blue;
    logic                 r_o_end;

    // decodes
    logic                 mem_we;
    logic                 rd_en;
    logic                 out_load;
    logic                 cfg_hit;
    logic                 px_write;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_W-1:0]    wr_word;
    logic [CY_W-1:0]      ry;
    logic [CX_W-1:0]      rx;
    logic [CY_W-1:0]      ry_raw;
    logic [CX_W-1:0]      rx_raw;
    logic                 win_ready;
    logic [GH_W-1:0]      y0;
    logic [COL_W-1:0]     x0;
    logic [SLOT_W:0]      slot0;
    logic [R_W-1:0]       dy;
    logic                 at_last_px;
    logic                 div_done;
    logic                 read_done;

    // clamp geometry
    always_comb begin
        if (r_cfg_w == '0) begin
            geo_w = GW_W'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            geo_w = GW_W'(MAX_WIDTH);
        end else begin
            geo_w = GW_W'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            geo_h = GH_W'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            geo_h = GH_W'(MAX_HEIGHT);
        end else begin
            geo_h = GH_W'(r_cfg_h);
        end
        if (32'(r_cfg_r) > MAX_RADIUS) begin
            geo_r = R_W'(MAX_RADIUS);
        end else begin
            geo_r = R_W'(r_cfg_r);
        end
    end

    assign cfg_hit  = i_cfg_wr_en;
    assign px_write = (r_item.kind == K_PIXEL) && (r_in_row < geo_h);
    assign wr_addr  = ADDR_W'(ADDR_W'(r_in_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_in_col));
    assign rd_addr  = ADDR_W'(ADDR_W'(r_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_xx));
    assign wr_word  = r_cfg_gray ? {r_item.red, r_item.red, r_item.red}
                                 : {r_item.blue, r_item.green, r_item.red};

    // window bounds for the next pending output
    always_comb begin
        ry_raw = CY_W'(r_out_row) + CY_W'(geo_r);
        rx_raw = CX_W'(r_out_col) + CX_W'(geo_r);
        ry     = (ry_raw > CY_W'(geo_h - 1'b1)) ? CY_W'(geo_h - 1'b1) : ry_raw;
        rx     = (rx_raw > CX_W'(geo_w - 1'b1)) ? CX_W'(geo_w - 1'b1) : rx_raw;
        win_ready = (ry < CY_W'(r_in_row)) ||
                    ((ry == CY_W'(r_in_row)) && (rx < CX_W'(r_in_col)));
        y0 = (r_out_row >= GH_W'(geo_r)) ? GH_W'(r_out_row - GH_W'(geo_r)) : '0;
        x0 = (CX_W'(r_out_col) >= CX_W'(geo_r)) ? COL_W'(CX_W'(r_out_col) - CX_W'(geo_r))
                                                : '0;
        dy = R_W'(r_out_row - y0);
        if (r_out_slot >= SLOT_W'(dy)) begin
            slot0 = (SLOT_W+1)'(r_out_slot) - (SLOT_W+1)'(dy);
        end else begin
            slot0 = (SLOT_W+1)'(r_out_slot) + (SLOT_W+1)'(STORE_ROWS) - (SLOT_W+1)'(dy);
        end
        at_last_px = (r_out_row == GH_W'(geo_h - 1'b1)) &&
                     (CX_W'(r_out_col) == CX_W'(geo_w - 1'b1));
    end

    assign read_done = r_issue_done && !r_pend;
    assign div_done  = (r_iter == IT_W'(SUM_W));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_item_valid) n_state = S_WRITE;
            S_WRITE: n_state = S_CHECK;
            S_CHECK: n_state = win_ready ? S_READ : S_IDLE;
            S_READ:  if (read_done) n_state = S_DSET;
            S_DSET:  n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_OUT;
            S_OUT:   if (!r_ovalid || i_pop) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state decodes
    always_comb begin
        o_item_pop = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE:  o_item_pop = i_item_valid;
            S_WRITE: mem_we     = px_write;
            S_READ:  rd_en      = !r_issue_done;
            S_OUT:   out_load   = !r_ovalid || i_pop;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // row store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_word;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_item <= i_item;
        end
        case (r_state)
            S_CHECK: begin
                r_x0         <= x0;
                r_x1         <= COL_W'(rx);
                r_y1         <= GH_W'(ry);
                r_xx         <= x0;
                r_yy         <= y0;
                r_slot       <= SLOT_W'(slot0);
                r_last       <= at_last_px;
                r_cnt        <= '0;
                r_issue_done <= 1'b0;
                r_pend       <= 1'b0;
                for (int c = 0; c < 3; c++) begin
                    r_sum[c] <= '0;
                end
            end
            S_READ: begin
                r_pend <= !r_issue_done;
                if (!r_issue_done) begin
                    if (r_xx == r_x1) begin
                        r_xx <= r_x0;
                        if (r_yy == r_y1) begin
                            r_issue_done <= 1'b1;
                        end
                        r_yy   <= r_yy + 1'b1;
                        r_slot <= (r_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : r_slot + 1'b1;
                    end else begin
                        r_xx <= r_xx + 1'b1;
                    end
                end
                if (r_pend) begin
                    r_cnt <= r_cnt + 1'b1;
                    for (int c = 0; c < 3; c++) begin
                        r_sum[c] <= r_sum[c] + SUM_W'(r_rd_data[c*SAMPLE_W +: SAMPLE_W]);
                    end
                end
            end
            S_DSET: begin
                r_iter <= '0;
                for (int c = 0; c < 3; c++) begin
                    r_quo[c] <= r_sum[c];
                    r_rem[c] <= '0;
                end
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle on each channel
                if (!div_done) begin
                    r_iter <= r_iter + 1'b1;
                    for (int c = 0; c < 3; c++) begin
                        if ({r_rem[c][CNT_W-1:0], r_quo[c][SUM_W-1]} >= (CNT_W+1)'(r_cnt)) begin
                            r_rem[c] <= {r_rem[c][CNT_W-1:0], r_quo[c][SUM_W-1]}
                                        - (CNT_W+1)'(r_cnt);
                            r_quo[c] <= {r_quo[c][SUM_W-2:0], 1'b1};
                        end else begin
                            r_rem[c] <= {r_rem[c][CNT_W-1:0], r_quo[c][SUM_W-1]};
                            r_quo[c] <= {r_quo[c][SUM_W-2:0], 1'b0};
                        end
                    end
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_o_red   <= r_quo[0][SAMPLE_W-1:0];
            r_o_green <= r_quo[1][SAMPLE_W-1:0];
            r_o_blue  <= r_quo[2][SAMPLE_W-1:0];
            r_o_end   <= r_last;
        end
    end

    // configuration and stream counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= RST_IMAGE_WIDTH;
            r_cfg_h    <= RST_IMAGE_HEIGHT;
            r_cfg_r    <= RST_WINDOW_RADIUS;
            r_cfg_gray <= 1'b0;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end
            if (cfg_hit) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:   r_cfg_w    <= i_cfg_data[CFG_WID_W-1:0];
                    REG_IMAGE_HEIGHT:  r_cfg_h    <= i_cfg_data[CFG_HGT_W-1:0];
                    REG_WINDOW_RADIUS: r_cfg_r    <= i_cfg_data[CFG_RAD_W-1:0];
                    REG_GRAY_INPUT:    r_cfg_gray <= i_cfg_data[0];
                    default: ;
                endcase
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_slot  <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_slot <= '0;
            end else begin
                if (mem_we) begin
                    if (CX_W'(r_in_col) + 1'b1 >= CX_W'(geo_w)) begin
                        r_in_col  <= '0;
                        r_in_row  <= r_in_row + 1'b1;
                        r_in_slot <= (r_in_slot == SLOT_W'(STORE_ROWS - 1)) ? '0
                                                                            : r_in_slot + 1'b1;
                    end else begin
                        r_in_col <= r_in_col + 1'b1;
                    end
                end
                if (out_load) begin
                    if (r_last) begin
                        r_in_col   <= '0;
                        r_in_row   <= '0;
                        r_in_slot  <= '0;
                        r_out_col  <= '0;
                        r_out_row  <= '0;
                        r_out_slot <= '0;
                    end else if (CX_W'(r_out_col) + 1'b1 >= CX_W'(geo_w)) begin
                        r_out_col  <= '0;
                        r_out_row  <= r_out_row + 1'b1;
                        r_out_slot <= (r_out_slot == SLOT_W'(STORE_ROWS - 1)) ? '0
                                                                              : r_out_slot + 1'b1;
                    end else begin
                        r_out_col <= r_out_col + 1'b1;
                    end
                end
            end
        end
    end

    assign o_empty      = !r_ovalid;
    assign o_blur_red   = r_o_red;
    assign o_blur_green = r_o_green;
    assign o_blur_blue  = r_o_blue;
    assign o_frame_end  = r_o_end;

endmodule

[design/rgb_box_blur_clipped_window.sv]
// ----------------------------------------------------------------------------
// rgb_box_blur_clipped_window: streaming box blur over a clipped window
// Input queue in front, line store with window accumulator and divider behind.
// ----------------------------------------------------------------------------
// Usage:
//   Input: push a beat when full is low. req_type 0 carries a pixel in raster
//   order, req_type 1 is a drain beat that only releases pending results.
//   Output: a result waits on the ports while empty is low; pop takes it.
//   Results come in raster order, radius rows plus radius pixels behind the
//   input; frame_end marks the frame's last pixel. Send drain beats at the
//   end of a frame to flush the tail.
//   Config: write width, height, radius or gray mode while idle; each write
//   restarts the frame.
//   Flow: one item is worked on at a time. For a beat that yields a result,
//   the clipped window is read from the line store one word a cycle, the
//   sums are divided by the window's pixel count, and SUM_W is the divider's
//   quotient width (16 with radius up to 7).
//   A two-beat input queue keeps accepting while the back end works or a
//   result waits; a stalled reader holds the back end in its output step.
//   Reset returns geometry to 640x480, radius 2, color mode, and clears the
//   input queue, the stream counters and the result valid flag; the line store itself is not cleared.
// ----------------------------------------------------------------------------
module rgb_box_blur_clipped_window #(
    parameter int unsigned MAX_WIDTH  = rgbbb_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = rgbbb_pkg::DEF_MAX_HEIGHT,
    parameter int unsigned MAX_RADIUS = rgbbb_pkg::DEF_MAX_RADIUS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [rgbbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rgbbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic                             i_req_type,
    input  logic [rgbbb_pkg::SAMPLE_W-1:0]   i_sample_red,
    input  logic [rgbbb_pkg::SAMPLE_W-1:0]   i_sample_green,
    input  logic [rgbbb_pkg::SAMPLE_W-1:0]   i_sample_blue,
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic [rgbbb_pkg::SAMPLE_W-1:0]   o_blur_red,
    output logic [rgbbb_pkg::SAMPLE_W-1:0]   o_blur_green,
    output logic [rgbbb_pkg::SAMPLE_W-1:0]   o_blur_blue,
    output logic                             o_frame_end
);
    import rgbbb_pkg::*;

    t_item               item;
    logic                item_valid;
    logic                item_pop;
    logic [FQ_CNT_W-1:0] fq_count;

    rgbbb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_req_type     (i_req_type),
        .i_sample_red   (i_sample_red),
        .i_sample_green (i_sample_green),
        .i_sample_blue  (i_sample_blue),
        .o_item_valid   (item_valid),
        .o_item         (item),
        .i_item_pop     (item_pop),
        .o_count        (fq_count)
    );

    rgbbb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_blur_red   (o_blur_red),
        .o_blur_green (o_blur_green),
        .o_blur_blue  (o_blur_blue),
        .o_frame_end  (o_frame_end)
    );

    a_fq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fq_count <= FQ_CNT_W'(FQ_DEPTH))
        else $error("input queue over depth");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> item_valid)
        else $error("accepted beat missing from input queue");

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_pop |-> item_valid)
        else $error("back end took from an empty queue");

endmodule
